// ----- rtl/core/oprc_pkg.sv -----
// shared types, constants and codes for the ordered packet rule classifier
// no dependencies; every other file in rtl/core except oprc_ram refers to it by scoped names
package oprc_pkg;

  localparam int unsigned DEFAULT_RULE_SLOTS = 64;
  localparam int unsigned ID_W = 32;
  localparam int unsigned PROTO_W = 8;
  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [PROTO_W-1:0] PROTO_ANY = '0;

  // command codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_IDS_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic direction;
    logic [PROTO_W-1:0] protocol;
    logic block_action;
    logic [ID_W-1:0] rule_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic verdict;
    logic matched;
    logic [ID_W-1:0] assigned_id;
  } rsp_t;

  // one stored rule, 42 bits
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic dir;
    logic [PROTO_W-1:0] proto;
    logic block;
  } rule_t;

  localparam int unsigned RULE_W = $bits(rule_t);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } sts_t;

endpackage

// ----- rtl/core/oprc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module oprc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/oprc_ctrl.sv -----
// controller state machine: accept, slot scan, drain, commit
// depends on oprc_pkg for the control and status structs
module oprc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  oprc_pkg::sts_t   sts_i,
  output oprc_pkg::ctl_t   ctl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/core/oprc_dp.sv -----
// datapath: request latch, rule ram, valid bits, scan trackers, id counter, result register
// depends on oprc_pkg and oprc_ram
module oprc_dp #(
  parameter int unsigned RULE_SLOTS = oprc_pkg::DEFAULT_RULE_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oprc_pkg::req_t   req_i,
  input  oprc_pkg::ctl_t   ctl_i,
  output oprc_pkg::sts_t   sts_o,
  output logic             done_o,
  output oprc_pkg::rsp_t   rsp_o
);

  localparam int unsigned IDX_W = $clog2(RULE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_SLOTS - 1);

  oprc_pkg::req_t req_q;
  logic [IDX_W-1:0] addr_q;
  logic cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic [RULE_SLOTS-1:0] valid_q, valid_d;
  logic valid_rd_q;
  logic [oprc_pkg::ID_W-1:0] next_id_q, next_id_d;

  logic free_found_q;
  logic [IDX_W-1:0] free_slot_q;
  logic hit_found_q;
  logic [IDX_W-1:0] hit_slot_q;
  logic best_found_q;
  logic [oprc_pkg::ID_W-1:0] best_id_q;
  logic best_block_q;

  logic done_q;
  oprc_pkg::rsp_t rsp_q, rsp_d;

  oprc_pkg::rule_t rd_rule, wr_rule;
  logic [oprc_pkg::RULE_W-1:0] rd_data;
  logic wr_en;

  logic cur_valid, take_free, take_hit, take_best, proto_ok;

  assign wr_rule.id = next_id_q + oprc_pkg::ID_W'(1);
  assign wr_rule.dir = req_q.direction;
  assign wr_rule.proto = req_q.protocol;
  assign wr_rule.block = req_q.block_action;

  assign wr_en = ctl_i.commit && (req_q.command == oprc_pkg::CMD_ADD)
      && (next_id_q != oprc_pkg::ID_MAX) && free_found_q;

  oprc_ram #(
    .WIDTH (oprc_pkg::RULE_W),
    .DEPTH (RULE_SLOTS)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (free_slot_q),
    .wdata_i (wr_rule),
    .re_i    (ctl_i.scan),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  assign rd_rule = oprc_pkg::rule_t'(rd_data);
  assign sts_o.last = (addr_q == LAST_IDX);

  // per-slot compare on the registered read
  always_comb begin
    cur_valid = cmp_vld_q && valid_rd_q;
    proto_ok = (rd_rule.proto == oprc_pkg::PROTO_ANY) || (rd_rule.proto == req_q.protocol);
    take_free = cmp_vld_q && !valid_rd_q && !free_found_q;
    take_hit = cur_valid && !hit_found_q && (rd_rule.id == req_q.rule_id);
    take_best = cur_valid && (rd_rule.dir == req_q.direction) && proto_ok
        && (!best_found_q || (rd_rule.id < best_id_q));
  end

  // commit: table update and result
  always_comb begin
    valid_d = valid_q;
    next_id_d = next_id_q;
    rsp_d = '0;
    case (req_q.command)
      oprc_pkg::CMD_ADD: begin
        if (next_id_q == oprc_pkg::ID_MAX) begin
          rsp_d.status = oprc_pkg::ST_IDS_EXHAUSTED;
        end else if (!free_found_q) begin
          rsp_d.status = oprc_pkg::ST_FULL;
        end else begin
          valid_d[free_slot_q] = 1'b1;
          next_id_d = wr_rule.id;
          rsp_d.status = oprc_pkg::ST_OK;
          rsp_d.assigned_id = wr_rule.id;
        end
      end
      oprc_pkg::CMD_DELETE: begin
        if (hit_found_q) begin
          valid_d[hit_slot_q] = 1'b0;
          rsp_d.status = oprc_pkg::ST_OK;
        end else begin
          rsp_d.status = oprc_pkg::ST_NOT_FOUND;
        end
      end
      oprc_pkg::CMD_CHECK: begin
        rsp_d.status = oprc_pkg::ST_OK;
        rsp_d.matched = best_found_q;
        rsp_d.verdict = best_found_q && best_block_q;
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      next_id_q <= '0;
      done_q <= 1'b0;
      cmp_vld_q <= 1'b0;
      addr_q <= '0;
    end else begin
      done_q <= ctl_i.commit;
      cmp_vld_q <= ctl_i.scan;
      if (ctl_i.load) begin
        addr_q <= '0;
      end else if (ctl_i.scan) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      if (ctl_i.commit) begin
        valid_q <= valid_d;
        next_id_q <= next_id_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b0;
      hit_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else if (ctl_i.load) begin
      free_found_q <= 1'b0;
      hit_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (take_free) begin
        free_found_q <= 1'b1;
      end
      if (take_hit) begin
        hit_found_q <= 1'b1;
      end
      if (take_best) begin
        best_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    cmp_idx_q <= addr_q;
    // valid bit read alongside the ram so both line up at compare time
    if (ctl_i.scan) begin
      valid_rd_q <= valid_q[addr_q];
    end
    if (take_free) begin
      free_slot_q <= cmp_idx_q;
    end
    if (take_hit) begin
      hit_slot_q <= cmp_idx_q;
    end
    if (take_best) begin
      best_id_q <= rd_rule.id;
      best_block_q <= rd_rule.block;
    end
    if (ctl_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o = rsp_q;

`ifndef SYNTHESIS
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_q |-> $past(ctl_i.commit))
    else $error("result strobe without a commit");

  a_id_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
      1'b1 |=> (next_id_q >= $past(next_id_q)))
    else $error("id counter went backwards");

  a_one_rule_per_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
      1'b1 |=> ($countones(valid_q) <= $past($countones(valid_q)) + 1))
    else $error("more than one rule added in a cycle");

  a_hit_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (hit_found_q && (cmp_vld_q || ctl_i.commit)) |-> valid_q[hit_slot_q])
    else $error("delete hit points at an empty slot");

  a_free_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (free_found_q && (cmp_vld_q || ctl_i.commit)) |-> !valid_q[free_slot_q])
    else $error("free slot points at a used slot");
`endif

endmodule

// ----- rtl/core/ordered_packet_rule_classifier_core.sv -----
// top level of the ordered first-match packet rule classifier
// depends on oprc_pkg, oprc_ctrl, oprc_dp (which holds oprc_ram)
//
//   channel   direction   handshake                   beat
//   request   in          start && !busy              oprc_pkg::req_t on req_i
//   result    out         done_o, one cycle, no stall oprc_pkg::rsp_t on rsp_o
//
// every command walks all RULE_SLOTS entries of the rule ram, one read per cycle
// busy through the scan, drain and commit states after the accepting edge; result strobe in the cycle after commit,
//   so a new request is accepted only once the previous one has finished its commit
// the single read port of the rule ram sets the scan pace: one slot compared per cycle
// reset clears the valid bits, the id counter and the controller; no clearing pass
// the receiver cannot stall: done_o is high for exactly one cycle per accepted beat
module ordered_packet_rule_classifier_core #(
  parameter int unsigned RULE_SLOTS = oprc_pkg::DEFAULT_RULE_SLOTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  oprc_pkg::req_t req_i,
  output logic           done_o,
  output oprc_pkg::rsp_t rsp_o
);

  // control and status between the sequencer and the datapath
  oprc_pkg::ctl_t ctl;
  oprc_pkg::sts_t sts;

  // sequencer: idle, scan every slot, drain the last ram read, commit
  oprc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // datapath: lowest free slot, id lookup and lowest-id match tracked during the scan
  oprc_dp #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
